// File: hdl/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg: shared types and codes for the sorted table
// Holds the key width, the command and status codes, and the control word
// that the top level broadcasts to every table cell.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;

  // Command codes on the cmd port.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes on the status port.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Broadcast to all cells: the search key and the shift to apply this cycle.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: hdl/sti_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_cell: one entry of the sorted table
// Holds a key, a payload and a valid flag, compares its key with the
// broadcast key, and on a shift takes the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module sti_cell #(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sti_pkg::cell_ctrl_t      ctrl,
  input  logic [PAYLOAD_BITS-1:0]  new_payload,
  input  logic                     prev_lt,
  input  logic [sti_pkg::KEY_W-1:0] below_key,
  input  logic [PAYLOAD_BITS-1:0]  below_payload,
  input  logic                     below_valid,
  input  logic [sti_pkg::KEY_W-1:0] above_key,
  input  logic [PAYLOAD_BITS-1:0]  above_payload,
  input  logic                     above_valid,
  output logic [sti_pkg::KEY_W-1:0] cell_key,
  output logic [PAYLOAD_BITS-1:0]  cell_payload,
  output logic                     cell_valid,
  output logic                     lt,
  output logic                     boundary
);
  import sti_pkg::*;

  // Entries are sorted, so lt forms a run from cell 0 upward; the boundary
  // cell is the first one that is not below the key.
  assign lt       = cell_valid && (cell_key < ctrl.key);
  assign boundary = !lt && prev_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctrl.shift_up && !lt) begin
      cell_valid <= prev_lt ? 1'b1 : below_valid;
    end else if (ctrl.shift_down && !lt) begin
      cell_valid <= above_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_up && !lt) begin
      cell_key     <= prev_lt ? ctrl.key : below_key;
      cell_payload <= prev_lt ? new_payload : below_payload;
    end else if (ctrl.shift_down && !lt) begin
      cell_key     <= above_key;
      cell_payload <= above_payload;
    end
  end

endmodule

// File: hdl/sorted_table_insert_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_core: sorted key/payload table
// Keeps up to TABLE_DEPTH entries in ascending key order in a row of cells.
// Insert places an entry before the first key that is not smaller; delete
// removes the first entry with an equal key and returns its payload.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                       Direction
// --------  --------------------------------------------  ---------
// command   start, busy, cmd, key, payload                in
// result    done, status, position, entry_count,          out
//           removed_payload
//
// A command transfer happens at a rising edge with start high and busy low.
// The table is updated at that same edge and the result is shown for exactly
// one cycle on the next cycle, flagged by done. One command every cycle; the
// whole insert or delete is one compare-and-shift step in the cell row.
// busy is high only during reset and the cycle after it. The receiver cannot
// stall, so results are never held back. Reset clears the valid flags and the
// entry count; stored keys and payloads are not cleared.
//
module sorted_table_insert_delete_core #(
  parameter int TABLE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64,
  localparam int POS_W       = $clog2(TABLE_DEPTH),
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [sti_pkg::KEY_W-1:0]   key,
  input  logic [PAYLOAD_BITS-1:0]     payload,
  output logic                        done,
  output logic [sti_pkg::STATUS_W-1:0] status,
  output logic [POS_W-1:0]            position,
  output logic [CNT_W-1:0]            entry_count,
  output logic [PAYLOAD_BITS-1:0]     removed_payload
);
  import sti_pkg::*;

  // Per-cell views of the row.
  logic [KEY_W-1:0]        cell_key     [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cell_valid;
  logic [TABLE_DEPTH-1:0]  cell_lt;
  logic [TABLE_DEPTH-1:0]  cell_bnd;
  logic [TABLE_DEPTH-1:0]  cell_match;

  logic [CNT_W-1:0]        fill_count;
  logic [CNT_W-1:0]        fill_count_next;
  logic                    accept;
  logic                    is_insert;
  logic                    full;
  logic                    found;
  cell_ctrl_t              ctrl;
  logic [POS_W-1:0]        bnd_pos;
  logic [PAYLOAD_BITS-1:0] bnd_payload;

  assign accept    = start && !busy;
  assign is_insert = (cmd == CMD_INSERT);
  assign full      = (fill_count == CNT_W'(TABLE_DEPTH));

  // The cell that sits at the boundary of the sorted run holds the first
  // equal key if there is one, because equal keys follow the smaller ones.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_match[i] = cell_bnd[i] && cell_valid[i] && (cell_key[i] == key);
    end
  end
  assign found = |cell_match;

  assign ctrl.key        = key;
  assign ctrl.shift_up   = accept && is_insert && !full;
  assign ctrl.shift_down = accept && !is_insert && found;

  // The row of cells. Cell 0 always counts as having a smaller neighbor below
  // it; the top cell sees an empty neighbor above it.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                    prev_lt;
    logic [KEY_W-1:0]        below_key;
    logic [PAYLOAD_BITS-1:0] below_payload;
    logic                    below_valid;
    logic [KEY_W-1:0]        above_key;
    logic [PAYLOAD_BITS-1:0] above_payload;
    logic                    above_valid;

    if (g == 0) begin : g_bottom
      assign prev_lt       = 1'b1;
      assign below_key     = '0;
      assign below_payload = '0;
      assign below_valid   = 1'b0;
    end else begin : g_inner_lo
      assign prev_lt       = cell_lt[g-1];
      assign below_key     = cell_key[g-1];
      assign below_payload = cell_payload[g-1];
      assign below_valid   = cell_valid[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_top
      assign above_key     = '0;
      assign above_payload = '0;
      assign above_valid   = 1'b0;
    end else begin : g_inner_hi
      assign above_key     = cell_key[g+1];
      assign above_payload = cell_payload[g+1];
      assign above_valid   = cell_valid[g+1];
    end

    sti_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_payload  (payload),
      .prev_lt      (prev_lt),
      .below_key    (below_key),
      .below_payload(below_payload),
      .below_valid  (below_valid),
      .above_key    (above_key),
      .above_payload(above_payload),
      .above_valid  (above_valid),
      .cell_key     (cell_key[g]),
      .cell_payload (cell_payload[g]),
      .cell_valid   (cell_valid[g]),
      .lt           (cell_lt[g]),
      .boundary     (cell_bnd[g])
    );
  end

  // Boundary is one-hot whenever the table is not full, so an OR of the
  // indexes picks out the single boundary cell; the payload OR takes only a matching cell.
  always_comb begin
    bnd_pos     = '0;
    bnd_payload = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cell_bnd[i]) begin
        bnd_pos = bnd_pos | POS_W'(i);
      end
      if (cell_match[i]) begin
        bnd_payload = bnd_payload | cell_payload[i];
      end
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (ctrl.shift_up) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctrl.shift_down) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      busy       <= 1'b0;
      done       <= accept;
      fill_count <= fill_count_next;
    end
  end

  // Result payload registers carry no reset; done qualifies them.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count <= fill_count_next;
      priority if (ctrl.shift_up) begin
        status          <= ST_DONE;
        position        <= bnd_pos;
        removed_payload <= '0;
      end else if (ctrl.shift_down) begin
        status          <= ST_DONE;
        position        <= bnd_pos;
        removed_payload <= bnd_payload;
      end else if (is_insert) begin
        status          <= ST_FULL;
        position        <= '0;
        removed_payload <= '0;
      end else begin
        status          <= ST_NOT_FOUND;
        position        <= '0;
        removed_payload <= '0;
      end
    end
  end

  // A result appears only in the cycle after a command transfer.
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without a command transfer");

  // Valid cells always number exactly the entry count.
  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(fill_count))
    else $error("valid flags disagree with the entry count");

  // Valid cells sit contiguously from cell 0.
  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid + TABLE_DEPTH'(1)))
    else $error("valid cells are not a contiguous run from the bottom");

  // A full refusal reports a full table.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> entry_count == CNT_W'(TABLE_DEPTH))
    else $error("full status reported with free entries");

endmodule
